// ----- design/lru_pkg.sv -----
// Shared widths and constants for the LRU frame tracker.
`timescale 1ns / 1ps

package lru_pkg;

	localparam int CFG_W = 4;   // frame count register width
	localparam int FIDX_W = 3;   // reported frame index width
	localparam int FAULT_W = 32;  // fault counter width

	localparam logic [CFG_W-1:0] FRAMES_RST = 4'd3;
	localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

endpackage

// ----- design/lru_if.sv -----
// Handshake interfaces: page reference, result word and frame count write.
`timescale 1ns / 1ps

interface lru_ref_if #(
	parameter int PAGE_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_number;
	logic                 last_ref;

	modport source(output valid, output page_number, output last_ref, input ready);
	modport sink(input valid, input page_number, input last_ref, output ready);
endinterface

interface lru_res_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [lru_pkg::FIDX_W-1:0]  frame_index;
	logic [lru_pkg::FAULT_W-1:0] fault_count;
	logic                        string_end;

	modport source(output valid, output hit, output frame_index, output fault_count,
		output string_end, input ready);
	modport sink(input valid, input hit, input frame_index, input fault_count,
		input string_end, output ready);
endinterface

interface lru_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [lru_pkg::CFG_W-1:0] frames_in_use;

	modport source(output valid, output frames_in_use, input ready);
	modport sink(input valid, input frames_in_use, output ready);
endinterface

// ----- design/lru_page_replacement.sv -----
// Fully associative LRU page frame tracker, top level.
//
//  channel | dir | handshake         | word
//  --------+-----+-------------------+-----------------------------------------------
//  cfg     | in  | valid/ready       | frames_in_use (4b)
//  refs    | in  | valid/ready       | page_number (PAGE_BITS), last_ref
//  result  | out | valid/ready       | hit, frame_index (3b), fault_count (32b), string_end
//
// One word per cycle sustained while the result is taken. A reference is registered on accept
// (s1), then the tag compare, victim pick and rank update run combinationally into the
// result register (s2).
// A stalled result holds s2; s1 still takes one more word, then refs.ready drops.
// arst_n clears all frames, ranks and the fault count; frame count returns to 3.
// cfg is always ready; it is to be written only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps

module lru_page_replacement #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	lru_cfg_if.sink   cfg,
	lru_ref_if.sink   refs,
	lru_res_if.source result
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;   // frame index and rank width
	localparam logic [IW-1:0] RANK_MAX = IW'(FRAMES - 1);

	// configuration
	logic [lru_pkg::CFG_W-1:0] frames_q;

	// input stage
	logic                 valid_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic                 last_s1;

	// result stage
	logic                         valid_s2;
	logic                         hit_s2;
	logic [lru_pkg::FIDX_W-1:0]   fidx_s2;
	logic [lru_pkg::FAULT_W-1:0]  fcnt_s2;
	logic                         end_s2;

	// frame state
	logic [PAGE_BITS-1:0]        page_q [FRAMES];
	logic [FRAMES-1:0]           fvalid_q;
	logic [IW-1:0]               rank_q [FRAMES];
	logic [lru_pkg::FAULT_W-1:0] fault_q;

	// lookup
	logic [FRAMES-1:0]           in_use;
	logic [FRAMES-1:0]           match;
	logic                        hit;
	logic [IW-1:0]               hit_idx;
	logic                        has_empty;
	logic [IW-1:0]               empty_idx;
	logic [IW-1:0]               vic_idx;
	logic [IW-1:0]               vic_rank;
	logic [IW-1:0]               slot;
	logic [IW-1:0]               age_limit;
	logic                        age_all;
	logic [IW-1:0]               rank_nxt [FRAMES];
	logic [lru_pkg::FAULT_W-1:0] fault_nxt;

	logic advance;   // s1 moves into s2 this cycle
	logic do_ref;    // a reference is applied to the frame state

	assign advance = !valid_s2 || result.ready;
	assign do_ref  = valid_s1 && advance;

	assign refs.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	assign result.valid       = valid_s2;
	assign result.hit         = hit_s2;
	assign result.frame_index = fidx_s2;
	assign result.fault_count = fcnt_s2;
	assign result.string_end  = end_s2;

	// Frame 0 is always in use; a count of 0 acts as 1 and counts above FRAMES
	// simply cover every frame.
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			in_use[i] = (i == 0) || (i < int'(frames_q));
			match[i]  = in_use[i] && fvalid_q[i] && (page_q[i] == page_s1);
		end

		// lowest index wins: scan downward
		hit       = 1'b0;
		hit_idx   = '0;
		has_empty = 1'b0;
		empty_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_idx = IW'(i);
			end
			if (in_use[i] && !fvalid_q[i]) begin
				has_empty = 1'b1;
				empty_idx = IW'(i);
			end
		end

		// oldest frame in use, lowest index on a tie
		vic_idx  = '0;
		vic_rank = rank_q[0];
		for (int i = 1; i < FRAMES; i++) begin
			if (in_use[i] && (rank_q[i] > vic_rank)) begin
				vic_idx  = IW'(i);
				vic_rank = rank_q[i];
			end
		end

		if (hit) begin
			slot      = hit_idx;
			age_limit = rank_q[hit_idx];
			age_all   = 1'b0;
		end else if (has_empty) begin
			slot      = empty_idx;
			age_limit = '0;
			age_all   = 1'b1;
		end else begin
			slot      = vic_idx;
			age_limit = vic_rank;
			age_all   = 1'b0;
		end

		// chosen frame goes to rank 0; younger frames age by one, saturating
		for (int i = 0; i < FRAMES; i++) begin
			rank_nxt[i] = rank_q[i];
			if (IW'(i) == slot) begin
				rank_nxt[i] = '0;
			end else if (in_use[i] && fvalid_q[i] && (age_all || (rank_q[i] < age_limit))
					&& (rank_q[i] != RANK_MAX)) begin
				rank_nxt[i] = rank_q[i] + 1'b1;
			end
		end

		if (hit || (fault_q == lru_pkg::FAULT_MAX)) begin
			fault_nxt = fault_q;
		end else begin
			fault_nxt = fault_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= lru_pkg::FRAMES_RST;
		end else if (cfg.valid) begin
			frames_q <= cfg.frames_in_use;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (refs.ready) begin
			valid_s1 <= refs.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (refs.valid && refs.ready) begin
			page_s1 <= refs.page_number;
			last_s1 <= refs.last_ref;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_ref) begin
			hit_s2  <= hit;
			fidx_s2 <= lru_pkg::FIDX_W'(slot);
			fcnt_s2 <= fault_nxt;
			end_s2  <= last_s1;
		end
	end

	// frame state; end of string empties everything after its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q <= '0;
			fault_q  <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (do_ref) begin
			if (last_s1) begin
				fvalid_q <= '0;
				fault_q  <= '0;
				for (int i = 0; i < FRAMES; i++) begin
					rank_q[i] <= '0;
				end
			end else begin
				fvalid_q[slot] <= 1'b1;
				fault_q        <= fault_nxt;
				for (int i = 0; i < FRAMES; i++) begin
					rank_q[i] <= rank_nxt[i];
				end
			end
		end
	end

	// page tags: only read behind a valid bit
	always_ff @(posedge clk) begin
		if (do_ref && !hit) begin
			page_q[slot] <= page_s1;
		end
	end

endmodule

// ----- design/lru_checker.sv -----
// Port-level checks for the LRU frame tracker, bound to the top level.
`timescale 1ns / 1ps

module lru_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        hit,
	input logic [lru_pkg::FIDX_W-1:0]  frame_index,
	input logic [lru_pkg::FAULT_W-1:0] fault_count,
	input logic                        string_end
);

	logic [lru_pkg::FAULT_W-1:0] prev_cnt_q;   // count the next result builds on
	logic                        out_acc;

	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cnt_q <= '0;
		end else if (out_acc) begin
			prev_cnt_q <= string_end ? '0 : fault_count;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(frame_index)
			&& $stable(fault_count) && $stable(string_end))
		else $error("result word changed while stalled");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	a_hit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && hit |-> fault_count == prev_cnt_q)
		else $error("fault count moved on a hit");

	a_miss_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !hit |-> (prev_cnt_q == lru_pkg::FAULT_MAX && fault_count == prev_cnt_q)
			|| (prev_cnt_q != lru_pkg::FAULT_MAX && fault_count == prev_cnt_q + 1'b1))
		else $error("fault count not advanced on a fault");

endmodule

bind lru_page_replacement lru_checker u_lru_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (refs.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.hit         (result.hit),
	.frame_index (result.frame_index),
	.fault_count (result.fault_count),
	.string_end  (result.string_end)
);

// ----- tb/lru_frame_checker.sv -----
// Checker for the LRU frame tracker: frame model, expected result words and compare.
`timescale 1ns / 1ps

module lru_frame_checker #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	lru_cfg_if   cfg,
	lru_ref_if   refs,
	lru_res_if   result,
	output int   fail_count,
	output int   waiting
);

	typedef struct packed {
		logic                        hit;
		logic [lru_pkg::FIDX_W-1:0]  frame_index;
		logic [lru_pkg::FAULT_W-1:0] fault_count;
		logic                        string_end;
	} res_word_t;

	logic [PAGE_BITS-1:0]        frame_page [FRAMES];
	logic                        frame_used [FRAMES];
	int                          frame_rank [FRAMES];
	logic [lru_pkg::FAULT_W-1:0] string_faults;
	logic [lru_pkg::CFG_W-1:0]   frame_limit;
	res_word_t                   pending_words [$];
	res_word_t                   want_w;
	res_word_t                   got_w;

	function automatic void clear_frames();
		for (int i = 0; i < FRAMES; i++) begin
			frame_page[i] = '0;
			frame_used[i] = 1'b0;
			frame_rank[i] = 0;
		end
		string_faults = '0;
	endfunction

	// frames in use below the limit (other than the chosen one) get one step older
	function automatic void age_frames(int count, int chosen, int limit);
		for (int i = 0; i < count; i++) begin
			if (i != chosen && frame_used[i] && frame_rank[i] < limit &&
				frame_rank[i] < FRAMES - 1)
				frame_rank[i]++;
		end
	endfunction

	function automatic res_word_t predict_reference(logic [PAGE_BITS-1:0] page, logic last);
		int        count;
		int        slot;
		logic      found;
		res_word_t w;
		count = (frame_limit == 0) ? 1 : (frame_limit > FRAMES) ? FRAMES : int'(frame_limit);
		slot  = 0;
		found = 1'b0;
		for (int i = 0; i < count && !found; i++) begin
			if (frame_used[i] && frame_page[i] == page) begin
				found = 1'b1;
				slot  = i;
			end
		end
		w.hit = found;
		if (found) begin
			age_frames(count, slot, frame_rank[slot]);
			frame_rank[slot] = 0;
		end else begin
			if (string_faults != lru_pkg::FAULT_MAX)
				string_faults++;
			for (int i = 0; i < count && !found; i++) begin
				if (!frame_used[i]) begin
					found = 1'b1;
					slot  = i;
				end
			end
			if (found) begin
				age_frames(count, slot, FRAMES);
			end else begin
				// oldest frame goes, lowest index on a tie
				slot = 0;
				for (int i = 1; i < count; i++)
					if (frame_rank[i] > frame_rank[slot])
						slot = i;
				age_frames(count, slot, frame_rank[slot]);
			end
			frame_page[slot] = page;
			frame_used[slot] = 1'b1;
			frame_rank[slot] = 0;
		end
		w.frame_index = lru_pkg::FIDX_W'(slot);
		w.fault_count = string_faults;
		w.string_end  = last;
		if (last)
			clear_frames();
		return w;
	endfunction

	function automatic void check_field(string name, logic [lru_pkg::FAULT_W-1:0] want,
		logic [lru_pkg::FAULT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frames();
			frame_limit = lru_pkg::FRAMES_RST;
			pending_words.delete();
			fail_count = 0;
		end else begin
			if (result.valid && result.ready) begin
				got_w = '{result.hit, result.frame_index, result.fault_count, result.string_end};
				if (pending_words.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %p",
						$time, got_w);
					fail_count++;
				end else begin
					want_w = pending_words.pop_front();
					check_field("hit", want_w.hit, got_w.hit);
					check_field("frame_index", want_w.frame_index, got_w.frame_index);
					check_field("fault_count", want_w.fault_count, got_w.fault_count);
					check_field("string_end", want_w.string_end, got_w.string_end);
				end
			end
			if (refs.valid && refs.ready)
				pending_words.push_back(predict_reference(refs.page_number, refs.last_ref));
			if (cfg.valid && cfg.ready)
				frame_limit = cfg.frames_in_use;
		end
		waiting = pending_words.size();
	end

endmodule

// ----- tb/lru_page_replacement_tb.sv -----
// Testbench top for the LRU frame tracker: clock, reset, stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module lru_page_replacement_tb;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 16;
	localparam int LATENCY   = 2;    // accept to result valid

	// receiver stall styles, each held for a random stretch
	typedef enum int {RX_FREE, RX_COIN, RX_QUARTER, RX_BLOCKS} rx_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   waiting;
	int   burst_left = 0;

	rx_style_t rx_style = RX_FREE;
	int        rx_left = 0;
	int        rx_block = 0;
	int        rx_tick = 0;

	lru_cfg_if                          cfg_ch ();
	lru_ref_if #(.PAGE_BITS(PAGE_BITS)) ref_ch ();
	lru_res_if                          res_ch ();

	lru_page_replacement #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.refs  (ref_ch),
		.result(res_ch)
	);

	lru_frame_checker #(
		.FRAMES   (FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_ch),
		.refs      (ref_ch),
		.result    (res_ch),
		.fail_count(fail_count),
		.waiting   (waiting)
	);

	always #1 clk = ~clk;

	// hard stop in case the handshake hangs
	initial begin
		#500000;
		$display("lru_page_replacement_tb: errors");
		$finish;
	end

	// receiver: switches between free flow, coin-flip ready, one-in-four ready
	// and occasional long blocks; each style is held for a random stretch
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_left  = $urandom_range(20, 300);
		end
		rx_left--;
		rx_tick++;
		case (rx_style)
			RX_FREE: begin
				res_ch.ready <= 1'b1;
			end
			RX_COIN: begin
				res_ch.ready <= 1'($urandom_range(0, 1));
			end
			RX_QUARTER: begin
				res_ch.ready <= (rx_tick % 4 == 0);
			end
			default: begin
				if (rx_block > 0) begin
					rx_block--;
					res_ch.ready <= 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					rx_block = $urandom_range(1, 12);
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
				end
			end
		endcase
	end

	// present one reference word and hold it until accepted
	task automatic send_word(logic [PAGE_BITS-1:0] page, logic last);
		@(negedge clk);
		ref_ch.valid       <= 1'b1;
		ref_ch.page_number <= page;
		ref_ch.last_ref    <= last;
		do @(posedge clk); while (!ref_ch.ready);
	endtask

	// sender idles in bursts: a gap of random length between random-length bursts
	task automatic feed(logic [PAGE_BITS-1:0] page, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			ref_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		send_word(page, last);
	endtask

	// stop sending and wait until every expected word has come back
	task automatic drain();
		@(negedge clk);
		ref_ch.valid <= 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	// frame count write, only with the block idle
	task automatic write_frames(logic [lru_pkg::CFG_W-1:0] count);
		drain();
		@(negedge clk);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.frames_in_use <= count;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// reference strings over a small drifting working set so hits and evictions
	// both happen; some far pages and the page extremes mixed in as noise
	task automatic run_strings(int n_items);
		logic [PAGE_BITS-1:0] base;
		logic [PAGE_BITS-1:0] page;
		int                   span;
		int                   left;
		int                   roll;
		base = PAGE_BITS'($urandom);
		span = $urandom_range(1, 12);
		left = $urandom_range(1, 60);
		for (int k = 0; k < n_items; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 85)
				page = base + PAGE_BITS'($urandom_range(0, span - 1));
			else if (roll < 95)
				page = PAGE_BITS'($urandom);
			else
				page = roll[0] ? '1 : '0;
			left--;
			feed(page, left == 0);
			if (left == 0) begin
				base = PAGE_BITS'($urandom);
				span = $urandom_range(1, 12);
				left = $urandom_range(1, 60);
			end
		end
	endtask

	initial begin
		logic [lru_pkg::CFG_W-1:0] phase_counts [12];
		phase_counts = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd12, 4'd2, 4'd7, 4'd9, 4'd5,
			4'd6, 4'd3};

		cfg_ch.valid         = 1'b0;
		cfg_ch.frames_in_use = '0;
		ref_ch.valid         = 1'b0;
		ref_ch.page_number   = '0;
		ref_ch.last_ref      = 1'b0;
		res_ch.ready         = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset frame count (3): fill, hit, LRU evictions, string end
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h1234, 1'b0);
		send_word(16'h5678, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b1);

		// single frame: every miss replaces frame 0
		write_frames(4'd1);
		send_word(16'h0000, 1'b0);
		send_word(16'h0007, 1'b0);
		send_word(16'h0007, 1'b0);

		// widen mid-string, fill the remaining frames
		write_frames(4'd8);
		for (int i = 0; i < 7; i++)
			send_word(PAGE_BITS'(16'h0010 + i), 1'b0);

		// narrow mid-string: pages in upper frames are out of reach
		write_frames(4'd2);
		send_word(16'h0013, 1'b0);

		// above the built count acts as full: upper frames come back intact
		write_frames(4'd15);
		send_word(16'h0014, 1'b0);
		send_word(16'h0013, 1'b1);

		// random phases, one frame count each; strings run across phase edges
		for (int ph = 0; ph < 12; ph++) begin
			write_frames(phase_counts[ph]);
			if (ph == 5) begin
				run_strings(40);
				drain();
				run_strings(45);
			end else begin
				run_strings(85);
			end
		end

		drain();
		repeat (4 * LATENCY) @(negedge clk);
		if (fail_count == 0)
			$display("lru_page_replacement_tb: clean");
		else
			$display("lru_page_replacement_tb: errors");
		$finish;
	end

endmodule
